// ----- sv/rv32dec_pkg.sv -----
// ----------------------------------------------------------------------------
// rv32dec_pkg
// Types and constants shared by the RV32I instruction decoder.
// ----------------------------------------------------------------------------
package rv32dec_pkg;

  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_SYSTEM = 7'b1110011;

  localparam logic [6:0]  FUNCT7_BASE = 7'b0000000;
  localparam logic [6:0]  FUNCT7_ALT  = 7'b0100000;
  localparam logic [11:0] CSR_ECALL   = 12'h000;
  localparam logic [11:0] CSR_EBREAK  = 12'h001;
  localparam logic [11:0] CSR_MRET    = 12'h302;

  localparam logic [8:0] FLAG_RS1  = 9'h001;
  localparam logic [8:0] FLAG_RS2  = 9'h002;
  localparam logic [8:0] FLAG_WRD  = 9'h004;
  localparam logic [8:0] FLAG_MRD  = 9'h008;
  localparam logic [8:0] FLAG_MWR  = 9'h010;
  localparam logic [8:0] FLAG_M2R  = 9'h020;
  localparam logic [8:0] FLAG_MSG  = 9'h040;
  localparam logic [8:0] FLAG_BR   = 9'h080;
  localparam logic [8:0] FLAG_JMP  = 9'h100;
  localparam logic [8:0] FLAG_NONE = 9'h000;

  typedef enum logic [5:0] {
    KIND_NOP, KIND_ILLEGAL,
    KIND_ADD, KIND_SUB, KIND_SLL, KIND_SLT, KIND_SLTU,
    KIND_XOR, KIND_SRL, KIND_SRA, KIND_OR, KIND_AND,
    KIND_ADDI, KIND_SLTI, KIND_SLTIU, KIND_XORI, KIND_ORI, KIND_ANDI,
    KIND_SLLI, KIND_SRLI, KIND_SRAI,
    KIND_LB, KIND_LH, KIND_LW, KIND_LBU, KIND_LHU,
    KIND_SB, KIND_SH, KIND_SW,
    KIND_BEQ, KIND_BNE, KIND_BLT, KIND_BGE, KIND_BLTU, KIND_BGEU,
    KIND_JAL, KIND_JALR, KIND_LUI, KIND_AUIPC,
    KIND_ECALL, KIND_EBREAK, KIND_MRET,
    KIND_CSRRW, KIND_CSRRS, KIND_CSRRC, KIND_CSRRWI, KIND_CSRRSI, KIND_CSRRCI
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [4:0]   src1_reg;
    logic [4:0]   src2_reg;
    logic [4:0]   dest_reg;
    logic [31:0]  immediate;
    logic [8:0]   control_flags;
    logic [2:0]   access_bytes;
    logic [11:0]  csr_address;
    logic [4:0]   csr_uimm;
  } dec_t;

endpackage

// ----- sv/rv32i_instruction_decoder_top.sv -----
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_top
// RV32I instruction decoder with registered input and result stages.
// ----------------------------------------------------------------------------
// Takes one 32-bit instruction word per item and returns its decoded form:
// kind code, register fields, sign-extended immediate, control flags, access
// size, CSR address and CSR immediate. One item per clock is sustained while the
// output is not held. The word is captured in the input register and decoded
// in a single pass into the result register when that register can load. While
// the output is held, the two registers fill with two items and then the input
// stalls.
// An all-zero word decodes as NOP; unmatched encodings decode as ILLEGAL.
module rv32i_instruction_decoder_top
  import rv32dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // instr_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // src1_reg[4:0], src2_reg[9:5], dest_reg[14:10], immediate[46:15],
  // control_flags[55:47], access_bytes[58:56], csr_address[70:59],
  // csr_uimm[75:71], zero pad[79:76]
  output logic [79:0] m_axis_tdata,
  output logic [5:0]  m_axis_tuser   // kind
);

  logic        in_valid;
  logic [31:0] in_word;
  logic        out_valid;
  dec_t        out_dec;
  dec_t        dec_next;
  logic        out_load;
  logic        in_load;

  assign out_load      = !out_valid || m_axis_tready;
  assign in_load       = !in_valid || out_load;
  assign s_axis_tready = in_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && s_axis_tvalid) begin
      in_word <= s_axis_tdata;
    end
    if (out_load && in_valid) begin
      out_dec <= dec_next;
    end
  end

  always_comb begin
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    op = in_word[6:0];
    f3 = in_word[14:12];
    f7 = in_word[31:25];

    dec_next               = '0;
    dec_next.kind          = KIND_ILLEGAL;
    dec_next.src1_reg      = in_word[19:15];
    dec_next.src2_reg      = in_word[24:20];
    dec_next.dest_reg      = in_word[11:7];

    case (op)
      OP_REG: begin
        if (f7 == FUNCT7_BASE) begin
          case (f3)
            3'd0: dec_next.kind = KIND_ADD;
            3'd1: dec_next.kind = KIND_SLL;
            3'd2: dec_next.kind = KIND_SLT;
            3'd3: dec_next.kind = KIND_SLTU;
            3'd4: dec_next.kind = KIND_XOR;
            3'd5: dec_next.kind = KIND_SRL;
            3'd6: dec_next.kind = KIND_OR;
            default: dec_next.kind = KIND_AND;
          endcase
        end else if (f7 == FUNCT7_ALT && f3 == 3'd0) begin
          dec_next.kind = KIND_SUB;
        end else if (f7 == FUNCT7_ALT && f3 == 3'd5) begin
          dec_next.kind = KIND_SRA;
        end
        if (dec_next.kind != KIND_ILLEGAL) begin
          dec_next.control_flags = FLAG_RS1 | FLAG_RS2 | FLAG_WRD;
        end
      end
      OP_IMM: begin
        dec_next.immediate = {{20{in_word[31]}}, in_word[31:20]};
        case (f3)
          3'd0: dec_next.kind = KIND_ADDI;
          3'd2: dec_next.kind = KIND_SLTI;
          3'd3: dec_next.kind = KIND_SLTIU;
          3'd4: dec_next.kind = KIND_XORI;
          3'd6: dec_next.kind = KIND_ORI;
          3'd7: dec_next.kind = KIND_ANDI;
          3'd1: begin
            if (f7 == FUNCT7_BASE) begin
              dec_next.kind      = KIND_SLLI;
              dec_next.immediate = {27'd0, in_word[24:20]};
            end
          end
          default: begin
            if (f7 == FUNCT7_BASE) begin
              dec_next.kind      = KIND_SRLI;
              dec_next.immediate = {27'd0, in_word[24:20]};
            end else if (f7 == FUNCT7_ALT) begin
              dec_next.kind      = KIND_SRAI;
              dec_next.immediate = {27'd0, in_word[24:20]};
            end
          end
        endcase
        if (dec_next.kind != KIND_ILLEGAL) begin
          dec_next.control_flags = FLAG_RS1 | FLAG_WRD;
        end
      end
      OP_LOAD: begin
        dec_next.immediate = {{20{in_word[31]}}, in_word[31:20]};
        case (f3)
          3'd0: begin
            dec_next.kind         = KIND_LB;
            dec_next.access_bytes = 3'd1;
          end
          3'd1: begin
            dec_next.kind         = KIND_LH;
            dec_next.access_bytes = 3'd2;
          end
          3'd2: begin
            dec_next.kind         = KIND_LW;
            dec_next.access_bytes = 3'd4;
          end
          3'd4: begin
            dec_next.kind         = KIND_LBU;
            dec_next.access_bytes = 3'd1;
          end
          3'd5: begin
            dec_next.kind         = KIND_LHU;
            dec_next.access_bytes = 3'd2;
          end
          default: dec_next.kind = KIND_ILLEGAL;
        endcase
        if (dec_next.kind != KIND_ILLEGAL) begin
          dec_next.control_flags = FLAG_RS1 | FLAG_WRD | FLAG_MRD | FLAG_M2R |
                                   (f3[2] ? FLAG_NONE : FLAG_MSG);
        end
      end
      OP_STORE: begin
        dec_next.immediate = {{20{in_word[31]}}, in_word[31:25], in_word[11:7]};
        case (f3)
          3'd0: begin
            dec_next.kind         = KIND_SB;
            dec_next.access_bytes = 3'd1;
          end
          3'd1: begin
            dec_next.kind         = KIND_SH;
            dec_next.access_bytes = 3'd2;
          end
          3'd2: begin
            dec_next.kind         = KIND_SW;
            dec_next.access_bytes = 3'd4;
          end
          default: dec_next.kind = KIND_ILLEGAL;
        endcase
        if (dec_next.kind != KIND_ILLEGAL) begin
          dec_next.control_flags = FLAG_RS1 | FLAG_RS2 | FLAG_MWR;
        end
      end
      OP_BRANCH: begin
        dec_next.immediate = {{20{in_word[31]}}, in_word[7], in_word[30:25],
                              in_word[11:8], 1'b0};
        case (f3)
          3'd0: dec_next.kind = KIND_BEQ;
          3'd1: dec_next.kind = KIND_BNE;
          3'd4: dec_next.kind = KIND_BLT;
          3'd5: dec_next.kind = KIND_BGE;
          3'd6: dec_next.kind = KIND_BLTU;
          3'd7: dec_next.kind = KIND_BGEU;
          default: dec_next.kind = KIND_ILLEGAL;
        endcase
        if (dec_next.kind != KIND_ILLEGAL) begin
          dec_next.control_flags = FLAG_RS1 | FLAG_RS2 | FLAG_BR;
        end
      end
      OP_JAL: begin
        dec_next.immediate     = {{12{in_word[31]}}, in_word[19:12], in_word[20],
                                  in_word[30:21], 1'b0};
        dec_next.kind          = KIND_JAL;
        dec_next.control_flags = FLAG_JMP | FLAG_WRD;
      end
      OP_JALR: begin
        if (f3 == 3'd0) begin
          dec_next.kind          = KIND_JALR;
          dec_next.control_flags = FLAG_JMP | FLAG_RS1 | FLAG_WRD;
          dec_next.immediate     = {{20{in_word[31]}}, in_word[31:20]};
        end
      end
      OP_LUI: begin
        dec_next.kind          = KIND_LUI;
        dec_next.control_flags = FLAG_WRD;
        dec_next.immediate     = {in_word[31:12], 12'd0};
      end
      OP_AUIPC: begin
        dec_next.kind          = KIND_AUIPC;
        dec_next.control_flags = FLAG_WRD;
        dec_next.immediate     = {in_word[31:12], 12'd0};
      end
      OP_SYSTEM: begin
        dec_next.csr_address = in_word[31:20];
        case (f3)
          3'd0: begin
            if (in_word[31:20] == CSR_ECALL) begin
              dec_next.kind = KIND_ECALL;
            end else if (in_word[31:20] == CSR_EBREAK) begin
              dec_next.kind = KIND_EBREAK;
            end else if (in_word[31:20] == CSR_MRET) begin
              dec_next.kind = KIND_MRET;
            end
          end
          3'd1: begin
            dec_next.kind          = KIND_CSRRW;
            dec_next.control_flags = FLAG_RS1 | FLAG_WRD;
          end
          3'd2: begin
            dec_next.kind          = KIND_CSRRS;
            dec_next.control_flags = FLAG_RS1 | FLAG_WRD;
          end
          3'd3: begin
            dec_next.kind          = KIND_CSRRC;
            dec_next.control_flags = FLAG_RS1 | FLAG_WRD;
          end
          3'd5: begin
            dec_next.kind          = KIND_CSRRWI;
            dec_next.control_flags = FLAG_WRD;
            dec_next.csr_uimm      = in_word[19:15];
          end
          3'd6: begin
            dec_next.kind          = KIND_CSRRSI;
            dec_next.control_flags = FLAG_WRD;
            dec_next.csr_uimm      = in_word[19:15];
          end
          3'd7: begin
            dec_next.kind          = KIND_CSRRCI;
            dec_next.control_flags = FLAG_WRD;
            dec_next.csr_uimm      = in_word[19:15];
          end
          default: dec_next.kind = KIND_ILLEGAL;
        endcase
      end
      default: dec_next.kind = KIND_ILLEGAL;
    endcase

    // all-zero word is a NOP; every other field is already zero
    if (in_word == 32'd0) begin
      dec_next.kind = KIND_NOP;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_dec.kind;
  assign m_axis_tdata  = {4'd0, out_dec.csr_uimm, out_dec.csr_address,
                          out_dec.access_bytes, out_dec.control_flags,
                          out_dec.immediate, out_dec.dest_reg,
                          out_dec.src2_reg, out_dec.src1_reg};

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RV32I instruction decoder.
// ----------------------------------------------------------------------------
// Instruction words go in over the input stream, and each decoded item is
// checked field by field against a decode computed in the bench. The stimulus
// is a set of edge-case words, one word for every kind but NOP, and a long
// random mix. Most of that mix is known opcodes with random fields, and the
// rest is raw noise or all-zero words. Both stream sides stall at random. One
// long output stall backs the pipeline up into the input.
module tb;
  import rv32dec_pkg::*;

  localparam logic [6:0] OP_MISC_MEM   = 7'b0001111;
  localparam logic [6:0] F7_MULDIV     = 7'b0000001;
  localparam logic [2:0] F3_ADD        = 3'd0;
  localparam logic [2:0] F3_SLL        = 3'd1;
  localparam logic [2:0] F3_SRL_SRA    = 3'd5;
  localparam logic [2:0] F3_LW         = 3'd2;
  localparam logic [2:0] F3_LBU        = 3'd4;
  localparam logic [2:0] F3_LOAD_RSVD  = 3'd3;
  localparam logic [2:0] F3_SW         = 3'd2;
  localparam logic [2:0] F3_STORE_RSVD = 3'd3;
  localparam logic [2:0] F3_BEQ        = 3'd0;
  localparam logic [2:0] F3_BR_RSVD    = 3'd2;
  localparam logic [2:0] F3_JALR       = 3'd0;
  localparam logic [2:0] F3_PRIV       = 3'd0;
  localparam logic [2:0] F3_CSR_RSVD   = 3'd4;
  localparam logic [2:0] F3_CSRRWI     = 3'd5;

  // kind tables indexed by funct3, entry 7 first
  localparam logic [7:0][5:0] REG_KINDS = {KIND_AND, KIND_OR, KIND_SRL, KIND_XOR,
                                           KIND_SLTU, KIND_SLT, KIND_SLL, KIND_ADD};
  localparam logic [7:0][5:0] IMM_KINDS = {KIND_ANDI, KIND_ORI, KIND_ILLEGAL, KIND_XORI,
                                           KIND_SLTIU, KIND_SLTI, KIND_ILLEGAL, KIND_ADDI};
  localparam logic [7:0][5:0] LOAD_KINDS = {KIND_ILLEGAL, KIND_ILLEGAL, KIND_LHU, KIND_LBU,
                                            KIND_ILLEGAL, KIND_LW, KIND_LH, KIND_LB};
  localparam logic [7:0][5:0] STORE_KINDS = {KIND_ILLEGAL, KIND_ILLEGAL, KIND_ILLEGAL,
                                             KIND_ILLEGAL, KIND_ILLEGAL, KIND_SW, KIND_SH,
                                             KIND_SB};
  localparam logic [7:0][5:0] BRANCH_KINDS = {KIND_BGEU, KIND_BLTU, KIND_BGE, KIND_BLT,
                                              KIND_ILLEGAL, KIND_ILLEGAL, KIND_BNE, KIND_BEQ};
  localparam logic [7:0][5:0] CSR_KINDS = {KIND_CSRRCI, KIND_CSRRSI, KIND_CSRRWI,
                                           KIND_ILLEGAL, KIND_CSRRC, KIND_CSRRS, KIND_CSRRW,
                                           KIND_ILLEGAL};
  localparam logic [9:0][6:0] OPCODES = {OP_REG, OP_IMM, OP_LOAD, OP_STORE, OP_BRANCH,
                                         OP_JAL, OP_JALR, OP_LUI, OP_AUIPC, OP_SYSTEM};
  localparam int HOLD_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // instr_word
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // src1, src2, dest, imm, flags, bytes, csr, uimm
  logic [5:0]  m_axis_tuser;        // kind

  dec_t pending_decodes[$];
  int   mismatch_count = 0;
  int   results_seen = 0;
  bit   idle_on = 1'b1;
  bit   hold_req = 1'b0;

  rv32i_instruction_decoder_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic dec_t predict_decode(logic [31:0] w);
    dec_t       d;
    logic [6:0] op;
    logic [6:0] f7;
    logic [2:0] f3;
    logic [31:0] imm_i;
    d = '0;
    d.kind = KIND_ILLEGAL;
    if (w == '0) begin
      d.kind = KIND_NOP;
      return d;
    end
    op = w[6:0];
    f3 = w[14:12];
    f7 = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    d.src1_reg = w[19:15];
    d.src2_reg = w[24:20];
    d.dest_reg = w[11:7];
    case (op)
      OP_REG: begin
        if (f7 == FUNCT7_BASE) d.kind = kind_t'(REG_KINDS[f3]);
        else if (f7 == FUNCT7_ALT && f3 == F3_ADD) d.kind = KIND_SUB;
        else if (f7 == FUNCT7_ALT && f3 == F3_SRL_SRA) d.kind = KIND_SRA;
        if (d.kind != KIND_ILLEGAL) d.control_flags = FLAG_RS1 | FLAG_RS2 | FLAG_WRD;
      end
      OP_IMM: begin
        d.immediate = imm_i;
        d.kind = kind_t'(IMM_KINDS[f3]);
        if (f3 == F3_SLL && f7 == FUNCT7_BASE) d.kind = KIND_SLLI;
        else if (f3 == F3_SRL_SRA && f7 == FUNCT7_BASE) d.kind = KIND_SRLI;
        else if (f3 == F3_SRL_SRA && f7 == FUNCT7_ALT) d.kind = KIND_SRAI;
        if (d.kind inside {KIND_SLLI, KIND_SRLI, KIND_SRAI})
          d.immediate = {27'd0, w[24:20]};
        if (d.kind != KIND_ILLEGAL) d.control_flags = FLAG_RS1 | FLAG_WRD;
      end
      OP_LOAD: begin
        d.immediate = imm_i;
        d.kind = kind_t'(LOAD_KINDS[f3]);
        if (d.kind != KIND_ILLEGAL) begin
          d.access_bytes = 3'(1 << f3[1:0]);
          d.control_flags = FLAG_RS1 | FLAG_WRD | FLAG_MRD | FLAG_M2R |
                            (f3[2] ? FLAG_NONE : FLAG_MSG);
        end
      end
      OP_STORE: begin
        d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        d.kind = kind_t'(STORE_KINDS[f3]);
        if (d.kind != KIND_ILLEGAL) begin
          d.access_bytes = 3'(1 << f3[1:0]);
          d.control_flags = FLAG_RS1 | FLAG_RS2 | FLAG_MWR;
        end
      end
      OP_BRANCH: begin
        d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        d.kind = kind_t'(BRANCH_KINDS[f3]);
        if (d.kind != KIND_ILLEGAL) d.control_flags = FLAG_RS1 | FLAG_RS2 | FLAG_BR;
      end
      OP_JAL: begin
        d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        d.kind = KIND_JAL;
        d.control_flags = FLAG_JMP | FLAG_WRD;
      end
      OP_JALR: begin
        if (f3 == F3_JALR) begin
          d.kind = KIND_JALR;
          d.immediate = imm_i;
          d.control_flags = FLAG_JMP | FLAG_RS1 | FLAG_WRD;
        end
      end
      OP_LUI, OP_AUIPC: begin
        d.kind = (op == OP_LUI) ? KIND_LUI : KIND_AUIPC;
        d.immediate = {w[31:12], 12'd0};
        d.control_flags = FLAG_WRD;
      end
      OP_SYSTEM: begin
        d.csr_address = w[31:20];
        if (f3 == F3_PRIV) begin
          if (w[31:20] == CSR_ECALL) d.kind = KIND_ECALL;
          else if (w[31:20] == CSR_EBREAK) d.kind = KIND_EBREAK;
          else if (w[31:20] == CSR_MRET) d.kind = KIND_MRET;
        end else if (f3 != F3_CSR_RSVD) begin
          d.kind = kind_t'(CSR_KINDS[f3]);
          if (f3[2]) begin
            d.control_flags = FLAG_WRD;
            d.csr_uimm = w[19:15];
          end else begin
            d.control_flags = FLAG_RS1 | FLAG_WRD;
          end
        end
      end
      default: ;
    endcase
    return d;
  endfunction

  // known opcode with random fields, funct7 and SYSTEM immediates biased
  function automatic logic [31:0] shaped_word();
    logic [31:0] w;
    w = $urandom;
    w[6:0] = OPCODES[$urandom_range(0, 9)];
    case ($urandom_range(0, 2))
      0: w[31:25] = FUNCT7_BASE;
      1: w[31:25] = FUNCT7_ALT;
      default: ;
    endcase
    if (w[6:0] == OP_SYSTEM) begin
      case ($urandom_range(0, 4))
        0: w[31:20] = CSR_ECALL;
        1: w[31:20] = CSR_EBREAK;
        2: w[31:20] = CSR_MRET;
        default: ;
      endcase
    end
    return w;
  endfunction

  function automatic logic [31:0] mixed_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) return '0;
    if (pick < 15) return $urandom;
    return shaped_word();
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 40) $display("[%0t] item %0d: %s", $realtime, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic send_word(logic [31:0] w);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    do @(posedge clk); while (!s_axis_tready);
    pending_decodes.push_back(predict_decode(w));
  endtask

  always begin
    @(negedge clk);
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clk);
      hold_req = 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    dec_t got;
    dec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind          = kind_t'(m_axis_tuser);
      got.src1_reg      = m_axis_tdata[4:0];
      got.src2_reg      = m_axis_tdata[9:5];
      got.dest_reg      = m_axis_tdata[14:10];
      got.immediate     = m_axis_tdata[46:15];
      got.control_flags = m_axis_tdata[55:47];
      got.access_bytes  = m_axis_tdata[58:56];
      got.csr_address   = m_axis_tdata[70:59];
      got.csr_uimm      = m_axis_tdata[75:71];
      if (pending_decodes.size() == 0) begin
        report_mismatch($sformatf("unexpected item, kind %0d", m_axis_tuser));
      end else begin
        want = pending_decodes.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.src1_reg !== want.src1_reg)
          report_mismatch($sformatf("src1_reg %0d, want %0d", got.src1_reg, want.src1_reg));
        if (got.src2_reg !== want.src2_reg)
          report_mismatch($sformatf("src2_reg %0d, want %0d", got.src2_reg, want.src2_reg));
        if (got.dest_reg !== want.dest_reg)
          report_mismatch($sformatf("dest_reg %0d, want %0d", got.dest_reg, want.dest_reg));
        if (got.immediate !== want.immediate)
          report_mismatch($sformatf("immediate %h, want %h", got.immediate, want.immediate));
        if (got.control_flags !== want.control_flags)
          report_mismatch($sformatf("control_flags %h, want %h",
                                    got.control_flags, want.control_flags));
        if (got.access_bytes !== want.access_bytes)
          report_mismatch($sformatf("access_bytes %0d, want %0d",
                                    got.access_bytes, want.access_bytes));
        if (got.csr_address !== want.csr_address)
          report_mismatch($sformatf("csr_address %h, want %h",
                                    got.csr_address, want.csr_address));
        if (got.csr_uimm !== want.csr_uimm)
          report_mismatch($sformatf("csr_uimm %0d, want %0d", got.csr_uimm, want.csr_uimm));
      end
      results_seen++;
    end
  end

  task automatic test_edge_words();
    send_word('0);
    send_word('1);
    send_word({FUNCT7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OP_REG});
    send_word({F7_MULDIV, 5'd1, 5'd2, F3_ADD, 5'd3, OP_REG});
    send_word({12'h7FF, 5'd1, F3_ADD, 5'd1, OP_IMM});
    send_word({12'h800, 5'd31, F3_ADD, 5'd0, OP_IMM});
    send_word({FUNCT7_BASE, 5'd31, 5'd5, F3_SLL, 5'd6, OP_IMM});
    send_word({FUNCT7_ALT, 5'd31, 5'd5, F3_SRL_SRA, 5'd6, OP_IMM});
    // shift with a bad funct7 keeps the sign-extended 12-bit field
    send_word({FUNCT7_ALT, 5'd7, 5'd5, F3_SLL, 5'd6, OP_IMM});
    send_word({12'hFFF, 5'd2, F3_LW, 5'd3, OP_LOAD});
    send_word({12'h001, 5'd2, F3_LBU, 5'd3, OP_LOAD});
    send_word({12'h7FF, 5'd2, F3_LOAD_RSVD, 5'd3, OP_LOAD});
    send_word({7'h40, 5'd9, 5'd8, F3_SW, 5'd0, OP_STORE});
    send_word({7'h3F, 5'd9, 5'd8, F3_STORE_RSVD, 5'd31, OP_STORE});
    send_word({7'h40, 5'd1, 5'd2, F3_BEQ, 5'd0, OP_BRANCH});
    send_word({7'h3F, 5'd1, 5'd2, F3_BR_RSVD, 5'd31, OP_BRANCH});
    send_word({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd1, OP_JAL});
    send_word({20'hFFFFF, 5'd1, OP_JAL});
    send_word({12'h123, 5'd4, ~F3_JALR, 5'd1, OP_JALR});
    send_word({20'hFFFFF, 5'd31, OP_LUI});
    send_word({CSR_ECALL, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM});
    send_word({CSR_EBREAK, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM});
    send_word({CSR_MRET, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM});
    send_word({12'h105, 5'd0, F3_PRIV, 5'd0, OP_SYSTEM});
    send_word({12'hABC, 5'd3, F3_CSR_RSVD, 5'd4, OP_SYSTEM});
    send_word({12'hFFF, 5'd31, F3_CSRRWI, 5'd31, OP_SYSTEM});
    send_word({4'b0000, 4'b1111, 4'b1111, 13'd0, OP_MISC_MEM});
  endtask

  task automatic test_every_kind();
    logic [31:0] w;
    dec_t        d;
    for (int k = KIND_ILLEGAL; k <= KIND_CSRRCI; k++) begin
      do begin
        w = shaped_word();
        d = predict_decode(w);
      end while (d.kind != kind_t'(k));
      send_word(w);
    end
  endtask

  task automatic test_output_stall();
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_word(shaped_word());
    idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    repeat (1400) send_word(mixed_word());
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    repeat (250) send_word(mixed_word());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_edge_words();
    test_every_kind();
    test_output_stall();
    test_random_mix();
    test_full_rate();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rv32dec_pkg.sv
sv/rv32i_instruction_decoder_top.sv
dv/tb.sv
